[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion helpers used by the list engine back end
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while in reset
`define OLDE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define OLDE_NEVER(label, clk, rst_n, cond, msg) \
    `OLDE_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[design/olde_pkg.sv]
// ---------------------------------------------------------------------------
// olde_pkg
// Types and constants shared by the ordered list delete engine.
// ---------------------------------------------------------------------------
`default_nettype none

package olde_pkg;

    // default list capacity
    localparam int OLDE_DEPTH = 16;
    // most results one dump may give
    localparam int MAX_RESULTS = 16;
    // command queue depth, a power of two
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // list operations
    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_REM_HEAD  = 3'd1,
        OP_REM_MATCH = 3'd2,
        OP_REM_TAIL  = 3'd3,
        OP_DUMP      = 3'd4
    } cmd_op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_RESP
    } back_state_t;

    // classified request handed from front to back
    typedef struct packed {
        cmd_op_t            op;
        logic signed [31:0] value;
    } cmd_t;

endpackage

`default_nettype wire

[design/olde_front.sv]
// ---------------------------------------------------------------------------
// olde_front
// Accepts requests, drops unused opcodes and classifies the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module olde_front
    import olde_pkg::*;
(
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] value,
    input  wire logic               q_full,
    output logic                    q_push,
    output cmd_t                    q_cmd
);

    logic op_known;

    // opcode classification
    always_comb
    begin
        op_known = 1'b0;
        unique case (cmd_op_t'(opcode))
            OP_APPEND, OP_REM_HEAD, OP_REM_MATCH, OP_REM_TAIL, OP_DUMP:
                op_known = 1'b1;
            default:
                op_known = 1'b0;
        endcase
    end

    // unused opcodes are taken and dropped here
    assign full         = q_full;
    assign q_push       = push && !q_full && op_known;
    assign q_cmd.op     = cmd_op_t'(opcode);
    assign q_cmd.value  = value;

endmodule

`default_nettype wire

[design/olde_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// olde_cmd_fifo
// Short request queue between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module olde_cmd_fifo
    import olde_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      empty
);

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg;
    logic [CMD_PTR_W:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (CMD_PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (CMD_PTR_W+1)'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/olde_back.sv]
// ---------------------------------------------------------------------------
// olde_back
// Carries out list requests on the entry memory and holds results in a result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module olde_back
    import olde_pkg::*;
#(
    parameter int DEPTH = OLDE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    input  wire logic               cmd_empty,
    output logic                    cmd_pop,
    output logic                    res_empty,
    input  wire logic               res_pop,
    output status_t                 res_status,
    output logic signed [31:0]      res_value,
    output logic                    res_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // entry memory
    logic signed [31:0] mem [DEPTH];
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic signed [31:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic signed [31:0] mem_rd_data_reg;

    // sequencer state
    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    cmd_op_t            mode_reg;
    cmd_op_t            mode_next;
    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;
    logic [CNT_W-1:0]   walk_len_reg;
    logic [CNT_W-1:0]   walk_len_next;
    logic [CNT_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   d_idx_reg;
    logic [CNT_W-1:0]   d_idx_next;
    logic               dv_reg;
    logic               dv_next;
    logic               found_reg;
    logic               found_next;
    status_t            status_reg;
    status_t            status_next;

    // result register
    logic               res_valid_reg;
    logic               res_valid_next;
    status_t            res_status_reg;
    logic signed [31:0] res_value_reg;
    logic               res_last_reg;
    logic               res_load;
    status_t            res_status_d;
    logic signed [31:0] res_value_d;
    logic               res_last_d;

    // walk helpers
    logic               out_free;
    logic               is_dump;
    logic               hit;
    logic               found_now;
    logic               walk_last;
    logic               proc;
    logic               issue;
    logic [CNT_W-1:0]   prev_idx;

    assign out_free  = !res_valid_reg || res_pop;
    assign is_dump   = (mode_reg == OP_DUMP);
    assign hit       = (mode_reg == OP_REM_HEAD) ? (d_idx_reg == '0)
                                                 : (mem_rd_data_reg == key_reg);
    assign found_now = found_reg || hit;
    assign walk_last = (d_idx_reg == walk_len_reg - CNT_W'(1));
    assign prev_idx  = d_idx_reg - CNT_W'(1);
    assign proc      = (state_reg == BK_WALK) && dv_reg && (!is_dump || out_free);
    assign issue     = (state_reg == BK_WALK) && (rd_ptr_reg < walk_len_reg)
                       && (!dv_reg || proc);

    // next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        walk_len_next = walk_len_reg;
        rd_ptr_next   = rd_ptr_reg;
        d_idx_next    = d_idx_reg;
        dv_next       = dv_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        cmd_pop       = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = '0;
        mem_wr_data   = cmd.value;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        res_load      = 1'b0;
        res_status_d  = status_reg;
        res_value_d   = '0;
        res_last_d    = 1'b1;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop     = 1'b1;
                    mode_next   = cmd.op;
                    key_next    = cmd.value;
                    rd_ptr_next = '0;
                    dv_next     = 1'b0;
                    found_next  = 1'b0;
                    unique case (cmd.op)
                        OP_APPEND:
                        begin
                            state_next = BK_RESP;
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = cnt_reg[IDX_W-1:0];
                                cnt_next    = cnt_reg + CNT_W'(1);
                                status_next = ST_OK;
                            end
                        end
                        OP_REM_TAIL:
                        begin
                            state_next = BK_RESP;
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next    = cnt_reg - CNT_W'(1);
                                status_next = ST_OK;
                            end
                        end
                        OP_REM_HEAD, OP_REM_MATCH, OP_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                state_next  = BK_RESP;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = BK_WALK;
                                walk_len_next = cnt_reg;
                                if (cmd.op == OP_DUMP && 32'(cnt_reg) > 32'(MAX_RESULTS))
                                begin
                                    walk_len_next = CNT_W'(MAX_RESULTS);
                                end
                            end
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_WALK:
            begin
                // fetch the next entry
                if (issue)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    d_idx_next  = rd_ptr_reg;
                    dv_next     = 1'b1;
                end
                else if (proc)
                begin
                    dv_next = 1'b0;
                end

                // consume the fetched entry
                if (proc)
                begin
                    if (is_dump)
                    begin
                        res_load     = 1'b1;
                        res_status_d = ST_OK;
                        res_value_d  = mem_rd_data_reg;
                        res_last_d   = walk_last;
                        if (walk_last)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        // once the victim is found, later entries slide down by one
                        if (found_reg)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = prev_idx[IDX_W-1:0];
                            mem_wr_data = mem_rd_data_reg;
                        end
                        else if (hit)
                        begin
                            found_next = 1'b1;
                        end
                        if (walk_last)
                        begin
                            state_next  = BK_RESP;
                            status_next = found_now ? ST_OK : ST_NOT_FOUND;
                            if (found_now)
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                    end
                end
            end

            BK_RESP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_valid_next = res_load ? 1'b1 : (res_pop ? 1'b0 : res_valid_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= OP_APPEND;
            walk_len_reg  <= '0;
            rd_ptr_reg    <= '0;
            d_idx_reg     <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            walk_len_reg  <= walk_len_next;
            rd_ptr_reg    <= rd_ptr_next;
            d_idx_reg     <= d_idx_next;
            dv_reg        <= dv_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (res_load)
        begin
            res_status_reg <= res_status_d;
            res_value_reg  <= res_value_d;
            res_last_reg   <= res_last_d;
        end
    end

    // entry memory ports, read data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_rd_data_reg <= mem[mem_rd_addr];
        end
    end

    assign res_empty  = !res_valid_reg;
    assign res_status = res_status_reg;
    assign res_value  = res_value_reg;
    assign res_last   = res_last_reg;

    // checks
    `OLDE_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > CNT_W'(DEPTH), "entry count over capacity")
    `OLDE_ASSERT(a_idle_no_data, clk, rst_n, (state_reg == BK_IDLE) |-> !dv_reg, "stale read data in idle")
    `OLDE_ASSERT(a_res_hold, clk, rst_n, (res_valid_reg && !res_pop) |=> (res_valid_reg && $stable(res_value_reg) && $stable(res_last_reg)), "waiting result overwritten")

endmodule

`default_nettype wire

[design/ordered_list_delete_engine.sv]
// ---------------------------------------------------------------------------
// ordered_list_delete_engine
// Ordered list of signed 32-bit values with append, removals and dump.
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  request   push / full        opcode, value
//  result    pop / empty        status, entry_value, last
//
//  append, remove tail, any request on an empty list: result straight from the respond state
//  remove head, remove match walk every entry, then give their result from the respond state
//  dump: entries show in list order from the head, one per cycle while pop keeps up
//  a stalled result pauses a dump walk; a two-deep queue holds further requests meanwhile
//  reset empties the list at once; entry storage is not cleared
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_list_delete_engine
    import olde_pkg::*;
#(
    parameter int DEPTH = OLDE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] value,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              status,
    output logic signed [31:0]      entry_value,
    output logic                    last
);

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    cmd_t    q_in;
    cmd_t    q_head;
    status_t res_status;

    // request decode
    olde_front u_front (
        .push   (push),
        .full   (full),
        .opcode (opcode),
        .value  (value),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_in)
    );

    // request queue
    olde_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty)
    );

    // list execution
    olde_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (q_head),
        .cmd_empty  (q_empty),
        .cmd_pop    (q_pop),
        .res_empty  (empty),
        .res_pop    (pop),
        .res_status (res_status),
        .res_value  (entry_value),
        .res_last   (last)
    );

    assign status = 2'(res_status);

endmodule

`default_nettype wire

[test/olde_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// olde_checker
// Watches the request and result queues of the ordered list delete engine,
// keeps its own copy of the list, predicts every result of each request and
// compares the results taken from the block against them in order.
// ---------------------------------------------------------------------------
module olde_checker
    import olde_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] value,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic [1:0]         status,
    input  wire logic signed [31:0] entry_value,
    input  wire logic               last,
    output int                      fail_count,
    output int                      pending
);

    // one predicted result
    typedef struct {
        status_t            status;
        logic signed [31:0] entry_value;
        logic               last;
    } list_result_t;

    list_result_t       result_q[$];
    logic signed [31:0] stored_list[$];

    // add one prediction to the back of the queue
    function automatic void queue_result(input status_t st, input logic signed [31:0] v,
                                         input logic lst);
        list_result_t r;
        r.status      = st;
        r.entry_value = v;
        r.last        = lst;
        result_q.push_back(r);
    endfunction

    // apply one request to the list copy and predict what it gives
    function automatic void predict_request(input logic [2:0] op,
                                            input logic signed [31:0] key);
        int n;
        int hit;
        hit = -1;
        case (op)
            OP_APPEND:
            begin
                if (stored_list.size() >= OLDE_DEPTH)
                    queue_result(ST_FULL, '0, 1'b1);
                else
                begin
                    stored_list.push_back(key);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_REM_HEAD, OP_REM_TAIL:
            begin
                if (stored_list.size() == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (op == OP_REM_HEAD)
                        void'(stored_list.pop_front());
                    else
                        void'(stored_list.pop_back());
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_REM_MATCH:
            begin
                if (stored_list.size() == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    // first equal entry from the head
                    for (int i = 0; i < stored_list.size() && hit < 0; i++)
                        if (stored_list[i] == key)
                            hit = i;
                    if (hit < 0)
                        queue_result(ST_NOT_FOUND, '0, 1'b1);
                    else
                    begin
                        stored_list.delete(hit);
                        queue_result(ST_OK, '0, 1'b1);
                    end
                end
            end
            OP_DUMP:
            begin
                n = stored_list.size();
                if (n > MAX_RESULTS)
                    n = MAX_RESULTS;
                if (n == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                for (int i = 0; i < n; i++)
                    queue_result(ST_OK, stored_list[i], i == n - 1);
            end
            // spare opcodes are dropped without a result
            default:
            begin
            end
        endcase
    endfunction

    // compare the result taken at this edge, then take in the new request
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            result_q.delete();
            stored_list.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with nothing expected: status %0d value %0d last %0d",
                           status, entry_value, last);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (entry_value !== want.entry_value)
                    begin
                        $error("entry_value: expected %0d, got %0d",
                               want.entry_value, entry_value);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                predict_request(opcode, value);
            pending <= result_q.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives requests into the ordered list delete engine and drains its
// results with random gaps on both sides; a checker beside the block
// predicts and compares every result and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
    import olde_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 200;
    localparam int          CALM_FROM    = 160;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          TAIL_CYCLES  = 60;
    // opcodes the block ignores
    localparam logic [2:0]  OP_SPARE_A   = 3'd5;
    localparam logic [2:0]  OP_SPARE_B   = 3'd6;
    localparam logic [2:0]  OP_SPARE_C   = 3'd7;
    localparam logic signed [31:0] ABSENT_KEY = 32'sh1234_5678;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [2:0]         opcode = '0;
    logic signed [31:0] value = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               last;

    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    logic               req_taken = 1'b0;
    logic               tx_idle_on = 1'b1;
    logic               rx_idle_on = 1'b1;
    logic               hold_req = 1'b0;
    logic signed [31:0] recent_vals[8];
    int                 recent_idx = 0;

    ordered_list_delete_engine i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .value       (value),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .entry_value (entry_value),
        .last        (last)
    );

    olde_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .value       (value),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .entry_value (entry_value),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // clock
    always #10 clk = ~clk;

    // request acceptance seen at the rising edge, read at the falling one
    always @(posedge clk)
    begin
        req_taken <= push && !full;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                pop <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    // value mix: small pool for duplicates, extremes, and fully random
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(0, 7);
            2:       return 32'sh8000_0000;
            3:       return 32'sh7fff_ffff;
            4:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // key for a match removal, mostly a value appended lately
    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return recent_vals[$urandom_range(0, 7)];
        return pick_value();
    endfunction

    // offer one request and wait until it is accepted
    task automatic send_request(input logic [2:0] op, input logic signed [31:0] key);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        push   <= 1'b1;
        opcode <= op;
        value  <= key;
        if (op == OP_APPEND)
        begin
            recent_vals[recent_idx] = key;
            recent_idx = (recent_idx + 1) % 8;
        end
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
    endtask

    // sender stops until every predicted result has been taken
    task automatic drain_results();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int                 sent;
        int                 roll;
        logic               fill_phase;
        logic signed [31:0] v;

        foreach (recent_vals[i])
            recent_vals[i] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every removal and a dump on the empty list
        send_request(OP_DUMP, '0);
        send_request(OP_REM_HEAD, '0);
        send_request(OP_REM_MATCH, 32'sd7);
        send_request(OP_REM_TAIL, '0);
        // spare opcodes, ignored
        send_request(OP_SPARE_A, -32'sd1);
        send_request(OP_SPARE_B, '0);
        send_request(OP_SPARE_C, 32'sh5555_5555);

        // fill the list with extremes and a duplicate pair
        for (int k = 0; k < OLDE_DEPTH; k++)
        begin
            case (k)
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = '0;
                3:       v = -32'sd1;
                4:       v = 32'sh5555_5555;
                5:       v = 32'shaaaa_aaaa;
                6:       v = 32'sd1;
                7, 8:    v = 32'sd7;
                default: v = k * 32'sh0101_0101;
            endcase
            send_request(OP_APPEND, v);
        end
        // append refused on a full list, then a full dump
        send_request(OP_APPEND, 32'sd3);
        send_request(OP_DUMP, '0);
        // key not present, first of a duplicate pair, head by match
        send_request(OP_REM_MATCH, ABSENT_KEY);
        send_request(OP_REM_MATCH, 32'sd7);
        send_request(OP_REM_MATCH, 32'sh8000_0000);
        send_request(OP_REM_HEAD, '0);
        send_request(OP_REM_TAIL, '0);
        send_request(OP_DUMP, '0);

        // random part: alternating fill and drain phases
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            fill_phase = ((sent / 25) % 2) == 0;
            if (sent == 40 && !hold_req)
                hold_req = 1'b1;
            if (sent == 100)
                drain_results();
            if (sent >= CALM_FROM)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                case ($urandom_range(0, 2))
                    0:       send_request(OP_SPARE_A, pick_value());
                    1:       send_request(OP_SPARE_B, pick_value());
                    default: send_request(OP_SPARE_C, pick_value());
                endcase
            end
            else
            begin
                if (roll < (fill_phase ? 75 : 22))
                    send_request(OP_APPEND, pick_value());
                else if (roll < (fill_phase ? 80 : 42))
                    send_request(OP_REM_HEAD, pick_value());
                else if (roll < (fill_phase ? 90 : 67))
                    send_request(OP_REM_MATCH, pick_key());
                else if (roll < (fill_phase ? 94 : 82))
                    send_request(OP_REM_TAIL, pick_value());
                else
                    send_request(OP_DUMP, pick_value());
                sent++;
            end
        end

        // wait for the last results, then a quiet tail
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
